>>> sv/fsmc_pkg.sv
// Shared types and constants for the flash save memory controller.
// Used by every module of the block; it depends on nothing else.
package fsmc_pkg;

   localparam int DATA_W      = 32;
   localparam int PAGE_WORDS  = 32;
   localparam int PAGE_IDX_W  = 5;
   localparam int DIVIDEND_W  = 16;
   localparam int OPCODE_W    = 8;
   localparam int STATUS_W    = 64;
   // Width of the fixed reciprocals; each is scaled by two to this power.
   localparam int RECIP_W     = 32;

   // Kind of request, carried on req_tuser.
   typedef enum logic [1:0] {
      MODE_CMD     = 2'd0,
      MODE_LOAD    = 2'd1,
      MODE_READ    = 2'd2,
      MODE_STATREG = 2'd3
   } req_mode_type;

   // Operating mode of the flash device.
   typedef enum logic [2:0] {
      OP_IDLE   = 3'd0,
      OP_ERASE  = 3'd1,
      OP_WRITE  = 3'd2,
      OP_READ   = 3'd3,
      OP_STATUS = 3'd4
   } op_mode_type;

   // Command opcodes, found in the top byte of a command word.
   localparam logic [OPCODE_W-1:0] OPC_EXECUTE    = 8'hD2;
   localparam logic [OPCODE_W-1:0] OPC_STATUS     = 8'hE1;
   localparam logic [OPCODE_W-1:0] OPC_READ       = 8'hF0;
   localparam logic [OPCODE_W-1:0] OPC_SETPAGE    = 8'h4B;
   localparam logic [OPCODE_W-1:0] OPC_ERASE      = 8'h78;
   localparam logic [OPCODE_W-1:0] OPC_WRITE      = 8'hB4;
   localparam logic [OPCODE_W-1:0] OPC_SETPAGE_ST = 8'hA5;

   // Status words loaded by the mode commands.
   localparam logic [STATUS_W-1:0] ST_STATUS  = 64'h1111_8001_00C2_0000;
   localparam logic [STATUS_W-1:0] ST_READ    = 64'h1111_8004_F000_0000;
   localparam logic [STATUS_W-1:0] ST_ERASE   = 64'h1111_8008_00C2_0000;
   localparam logic [STATUS_W-1:0] ST_SETPAGE = 64'h1111_8004_00C2_0000;

   localparam logic [DATA_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;

endpackage

>>> sv/flash_save_memory_controller_core.sv
// Top level of the flash save memory controller: command decoder, control
// sequencer and output register. Depends on fsmc_pkg, fsmc_ram, fsmc_mod_unit.
//
// This block models a cartridge flash save memory of FLASH_WORDS 32-bit words
// in pages of 32 words, driven by one request stream and answering on one
// response stream. req_tuser selects the request kind: command write, page
// buffer load, data read, or status register read. Items are handled one at a
// time and req_tready is high only while the controller is idle. After reset
// the flash array is swept to all ones, one word per cycle, and the first
// transfer is taken only once the sweep is done. Command writes that only
// change mode and page buffer loads are handled in the idle state. Set-page
// commands and read-mode data reads wrap the page number or word address in a
// remainder unit that multiplies by a fixed reciprocal and corrects once,
// while the controller waits in S_DIV. A read-mode data read then reads the
// flash, and reads a second word when an odd offset straddles two words,
// before its result goes to the output register. An execute in erase or write
// mode walks the 32 page words through the flash write port. A status read
// pushes one or two words through the output register.
// The output register decouples the response side: a result waits there while
// the controller goes on with the next request, and stalls only when a new
// result meets a full register. Both memories are accessed by one step at a
// time, so a write and a read of the same entry never overlap.
module flash_save_memory_controller_core #(
   parameter int FLASH_WORDS = 32768
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] command, [36:32] buffer_index, [68:37] buffer_data,
   // [84:69] dma_offset, [87:85] zero
   input  logic [87:0]  req_tdata,
   // [1:0] mode
   input  logic [1:0]   req_tuser,
   // last_word
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] read_data
   output logic [31:0]  rsp_tdata,
   // last
   output logic         rsp_tlast
);

   localparam int AW         = $clog2(FLASH_WORDS);
   localparam int RW         = AW + 1;
   localparam int PAGE_COUNT = FLASH_WORDS / fsmc_pkg::PAGE_WORDS;
   localparam int PW         = $clog2(PAGE_COUNT);
   localparam int WALK_W     = fsmc_pkg::PAGE_IDX_W + 1;
   localparam int DW         = fsmc_pkg::DATA_W;
   localparam int RCW        = fsmc_pkg::RECIP_W;
   localparam logic [RW-1:0] FLASH_SIZE = RW'(FLASH_WORDS);
   localparam logic [RW-1:0] PAGE_SIZE  = RW'(PAGE_COUNT);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(FLASH_WORDS - 1);
   localparam logic [RCW-1:0] FLASH_RECIP = RCW'((64'd1 << RCW) / FLASH_WORDS);
   localparam logic [RCW-1:0] PAGE_RECIP  = RCW'((64'd1 << RCW) / PAGE_COUNT);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_WALK  = 7'b0001000,
      S_RDB   = 7'b0010000,
      S_RDC   = 7'b0100000,
      S_PUSH  = 7'b1000000
   } state_type;

   // Request fields.
   logic [31:0]                    req_command;
   logic [fsmc_pkg::PAGE_IDX_W-1:0] req_buffer_index;
   logic [DW-1:0]                  req_buffer_data;
   logic [15:0]                    req_dma_offset;
   fsmc_pkg::req_mode_type         req_mode;
   logic [fsmc_pkg::OPCODE_W-1:0]  req_opcode;

   assign req_command      = req_tdata[31:0];
   assign req_buffer_index = req_tdata[36:32];
   assign req_buffer_data  = req_tdata[68:37];
   assign req_dma_offset   = req_tdata[84:69];
   assign req_mode         = fsmc_pkg::req_mode_type'(req_tuser);
   assign req_opcode       = req_command[31:24];

   // Control state.
   state_type                      state_ff, state_in;
   fsmc_pkg::op_mode_type          op_mode_ff, op_mode_in;
   logic [fsmc_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [PW-1:0]                  page_ff, page_in;
   logic [AW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [WALK_W-1:0]              walk_cnt_ff, walk_cnt_in;
   logic                           pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload held for the item in progress.
   fsmc_pkg::req_mode_type         item_mode_ff, item_mode_in;
   logic [fsmc_pkg::OPCODE_W-1:0]  item_opc_ff, item_opc_in;
   logic                           item_odd_ff, item_odd_in;
   logic                           item_last_ff, item_last_in;
   logic                           walk_erase_ff, walk_erase_in;
   logic [fsmc_pkg::PAGE_IDX_W-1:0] pidx_ff, pidx_in;
   logic [AW-1:0]                  w0_ff, w0_in;
   logic [15:0]                    hi_ff, hi_in;
   logic [DW-1:0]                  res_data_ff, res_data_in;
   logic                           res_last_ff, res_last_in;
   logic                           more_ff, more_in;
   logic [DW-1:0]                  rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Memory and remainder unit connections.
   logic                           fl_wr_en, fl_rd_en;
   logic [AW-1:0]                  fl_wr_addr, fl_rd_addr;
   logic [DW-1:0]                  fl_wr_data, fl_rd_data;
   logic                           pb_wr_en, pb_rd_en;
   logic [fsmc_pkg::PAGE_IDX_W-1:0] pb_rd_addr;
   logic [DW-1:0]                  pb_rd_data;
   logic                           mod_start, mod_done;
   logic [fsmc_pkg::DIVIDEND_W-1:0] mod_dividend;
   logic [RW-1:0]                  mod_divisor;
   logic [RCW-1:0]                 mod_recip;
   logic [AW-1:0]                  mod_rem;

   // Page-walk and second-word addresses; both stay below twice the flash
   // size, so one compare and subtract wraps them.
   logic [RW-1:0]                  walk_sum, w1_sum;
   logic [AW-1:0]                  walk_addr, w1_addr;
   logic                           out_free;

   always_comb begin
      walk_sum  = RW'({page_ff, pidx_ff});
      walk_addr = (walk_sum >= FLASH_SIZE) ? AW'(walk_sum - FLASH_SIZE) : AW'(walk_sum);
      w1_sum    = RW'(w0_ff) + 1'b1;
      w1_addr   = (w1_sum >= FLASH_SIZE) ? AW'(w1_sum - FLASH_SIZE) : AW'(w1_sum);
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in      = state_ff;
      op_mode_in    = op_mode_ff;
      status_in     = status_ff;
      page_in       = page_ff;
      clr_cnt_in    = clr_cnt_ff;
      walk_cnt_in   = walk_cnt_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      item_mode_in  = item_mode_ff;
      item_opc_in   = item_opc_ff;
      item_odd_in   = item_odd_ff;
      item_last_in  = item_last_ff;
      walk_erase_in = walk_erase_ff;
      pidx_in       = pidx_ff;
      w0_in         = w0_ff;
      hi_in         = hi_ff;
      res_data_in   = res_data_ff;
      res_last_in   = res_last_ff;
      more_in       = more_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      req_tready    = 1'b0;
      fl_wr_en      = 1'b0;
      fl_wr_addr    = walk_addr;
      fl_wr_data    = walk_erase_ff ? fsmc_pkg::ERASED_WORD : pb_rd_data;
      fl_rd_en      = 1'b0;
      fl_rd_addr    = mod_rem;
      pb_wr_en      = 1'b0;
      pb_rd_en      = 1'b0;
      pb_rd_addr    = walk_cnt_ff[fsmc_pkg::PAGE_IDX_W-1:0];
      mod_start     = 1'b0;
      mod_dividend  = {1'b0, req_dma_offset[15:1]};
      mod_divisor   = FLASH_SIZE;
      mod_recip     = FLASH_RECIP;

      unique case (state_ff)
         S_CLEAR: begin
            fl_wr_en   = 1'b1;
            fl_wr_addr = clr_cnt_ff;
            fl_wr_data = fsmc_pkg::ERASED_WORD;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               item_mode_in = req_mode;
               item_opc_in  = req_opcode;
               item_odd_in  = req_dma_offset[0];
               item_last_in = req_tlast;
               unique case (req_mode)
                  fsmc_pkg::MODE_CMD: begin
                     case (req_opcode)
                        fsmc_pkg::OPC_EXECUTE: begin
                           // Erase and write walk the page; every other mode
                           // only drops back to idle.
                           op_mode_in = fsmc_pkg::OP_IDLE;
                           if (op_mode_ff == fsmc_pkg::OP_ERASE ||
                               op_mode_ff == fsmc_pkg::OP_WRITE) begin
                              walk_cnt_in   = '0;
                              walk_erase_in = (op_mode_ff == fsmc_pkg::OP_ERASE);
                              state_in      = S_WALK;
                           end
                        end
                        fsmc_pkg::OPC_STATUS: begin
                           op_mode_in = fsmc_pkg::OP_STATUS;
                           status_in  = fsmc_pkg::ST_STATUS;
                        end
                        fsmc_pkg::OPC_READ: begin
                           op_mode_in = fsmc_pkg::OP_READ;
                           status_in  = fsmc_pkg::ST_READ;
                        end
                        fsmc_pkg::OPC_ERASE: begin
                           op_mode_in = fsmc_pkg::OP_ERASE;
                           status_in  = fsmc_pkg::ST_ERASE;
                        end
                        fsmc_pkg::OPC_WRITE: begin
                           op_mode_in = fsmc_pkg::OP_WRITE;
                        end
                        fsmc_pkg::OPC_SETPAGE,
                        fsmc_pkg::OPC_SETPAGE_ST: begin
                           // The page number wraps modulo the page count.
                           mod_start    = 1'b1;
                           mod_dividend = req_command[15:0];
                           mod_divisor  = PAGE_SIZE;
                           mod_recip    = PAGE_RECIP;
                           state_in     = S_DIV;
                        end
                        default: begin
                        end
                     endcase
                  end

                  fsmc_pkg::MODE_LOAD: begin
                     pb_wr_en = (op_mode_ff == fsmc_pkg::OP_WRITE);
                  end

                  fsmc_pkg::MODE_READ: begin
                     if (op_mode_ff == fsmc_pkg::OP_READ) begin
                        // Byte address is twice the offset, so the first word
                        // sits at half the offset, wrapped to the array size.
                        mod_start = 1'b1;
                        state_in  = S_DIV;
                     end else if (op_mode_ff == fsmc_pkg::OP_STATUS) begin
                        res_data_in = status_ff[63:32];
                        res_last_in = 1'b0;
                        more_in     = 1'b1;
                        state_in    = S_PUSH;
                     end
                  end

                  fsmc_pkg::MODE_STATREG: begin
                     res_data_in = status_ff[63:32];
                     res_last_in = 1'b1;
                     more_in     = 1'b0;
                     state_in    = S_PUSH;
                  end

                  default: begin
                  end
               endcase
            end
         end

         S_DIV: begin
            if (mod_done) begin
               if (item_mode_ff == fsmc_pkg::MODE_CMD) begin
                  page_in = mod_rem[PW-1:0];
                  if (item_opc_ff == fsmc_pkg::OPC_SETPAGE_ST) begin
                     status_in = fsmc_pkg::ST_SETPAGE;
                  end
                  state_in = S_IDLE;
               end else begin
                  fl_rd_en = 1'b1;
                  w0_in    = mod_rem;
                  state_in = S_RDB;
               end
            end
         end

         S_WALK: begin
            // Page buffer read for one word overlaps the flash write of the
            // word before it.
            if (!walk_cnt_ff[WALK_W-1]) begin
               pb_rd_en    = 1'b1;
               pend_in     = 1'b1;
               pidx_in     = walk_cnt_ff[fsmc_pkg::PAGE_IDX_W-1:0];
               walk_cnt_in = walk_cnt_ff + 1'b1;
            end
            fl_wr_en = pend_ff;
            if (walk_cnt_ff[WALK_W-1] && !pend_ff) begin
               state_in = S_IDLE;
            end
         end

         S_RDB: begin
            if (!item_odd_ff) begin
               res_data_in = fl_rd_data;
               res_last_in = item_last_ff;
               more_in     = 1'b0;
               state_in    = S_PUSH;
            end else begin
               // An odd offset joins the upper half of this word with the
               // lower half of the next one.
               hi_in      = fl_rd_data[31:16];
               fl_rd_en   = 1'b1;
               fl_rd_addr = w1_addr;
               state_in   = S_RDC;
            end
         end

         S_RDC: begin
            res_data_in = {fl_rd_data[15:0], hi_ff};
            res_last_in = item_last_ff;
            more_in     = 1'b0;
            state_in    = S_PUSH;
         end

         S_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_last_in  = res_last_ff;
               if (more_ff) begin
                  res_data_in = status_ff[31:0];
                  res_last_in = 1'b1;
                  more_in     = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         op_mode_ff   <= fsmc_pkg::OP_IDLE;
         status_ff    <= '0;
         page_ff      <= '0;
         clr_cnt_ff   <= '0;
         walk_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_mode_ff   <= op_mode_in;
         status_ff    <= status_in;
         page_ff      <= page_in;
         clr_cnt_ff   <= clr_cnt_in;
         walk_cnt_ff  <= walk_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_mode_ff  <= item_mode_in;
      item_opc_ff   <= item_opc_in;
      item_odd_ff   <= item_odd_in;
      item_last_ff  <= item_last_in;
      walk_erase_ff <= walk_erase_in;
      pidx_ff       <= pidx_in;
      w0_ff         <= w0_in;
      hi_ff         <= hi_in;
      res_data_ff   <= res_data_in;
      res_last_ff   <= res_last_in;
      more_ff       <= more_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Flash array, cleared to all ones by the sweep after reset.
   fsmc_ram #(
      .DEPTH  (FLASH_WORDS),
      .ADDR_W (AW)
   ) u_flash (
      .clock   (clock),
      .wr_en   (fl_wr_en),
      .wr_addr (fl_wr_addr),
      .wr_data (fl_wr_data),
      .rd_en   (fl_rd_en),
      .rd_addr (fl_rd_addr),
      .rd_data (fl_rd_data)
   );

   // Page buffer, written by loads in write mode and read by the page walk.
   fsmc_ram #(
      .DEPTH  (fsmc_pkg::PAGE_WORDS),
      .ADDR_W (fsmc_pkg::PAGE_IDX_W)
   ) u_page_buf (
      .clock   (clock),
      .wr_en   (pb_wr_en),
      .wr_addr (req_buffer_index),
      .wr_data (req_buffer_data),
      .rd_en   (pb_rd_en),
      .rd_addr (pb_rd_addr),
      .rd_data (pb_rd_data)
   );

   // Shared remainder unit for page numbers and read word addresses.
   fsmc_mod_unit #(
      .REM_W (AW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .recip     (mod_recip),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sv/fsmc_ram.sv
// Simple dual-port synchronous memory: one write port, one read port with a
// registered read. Depends on fsmc_pkg for the data width.
module fsmc_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [fsmc_pkg::DATA_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [fsmc_pkg::DATA_W-1:0]  rd_data
);

   logic [fsmc_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [fsmc_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fsmc_mod_unit.sv
// Remainder unit: reduces a 16-bit value modulo a fixed divisor by multiplying
// with its reciprocal and correcting once in registered steps. Depends on fsmc_pkg.
module fsmc_mod_unit #(
   parameter int REM_W = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fsmc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [REM_W:0]                    divisor,
   input  logic [fsmc_pkg::RECIP_W-1:0]      recip,
   output logic                              done,
   output logic [REM_W-1:0]                  remainder
);

   localparam int XW  = fsmc_pkg::DIVIDEND_W;
   localparam int RCW = fsmc_pkg::RECIP_W;
   localparam int PRW = XW + RCW;
   localparam int BKW = XW + REM_W + 1;

   localparam logic [1:0] STEP_QUOT = 2'd0;
   localparam logic [1:0] STEP_BACK = 2'd1;
   localparam logic [1:0] STEP_FIX  = 2'd2;

   logic             busy_ff;
   logic             done_ff;
   logic [1:0]       step_ff;
   logic [XW-1:0]    num_ff;
   logic [REM_W:0]   div_ff;
   logic [RCW-1:0]   recip_ff;
   logic [XW-1:0]    quot_ff;
   logic [XW-1:0]    rem_ff;
   logic [PRW-1:0]   prod;
   logic [BKW-1:0]   back;
   logic [XW-1:0]    est;
   logic [BKW-1:0]   fix;

   // The reciprocal is rounded down, so the quotient estimate is low by at
   // most one and a single conditional subtract finishes the remainder.
   always_comb begin
      prod = PRW'(num_ff) * PRW'(recip_ff);
      back = BKW'(quot_ff) * BKW'(div_ff);
      est  = num_ff - back[XW-1:0];
      fix  = (BKW'(rem_ff) >= BKW'(div_ff)) ? (BKW'(rem_ff) - BKW'(div_ff))
                                            : BKW'(rem_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_QUOT;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_QUOT;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_FIX) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff   <= dividend;
         div_ff   <= divisor;
         recip_ff <= recip;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_QUOT: quot_ff <= prod[PRW-1:RCW];
            STEP_BACK: rem_ff  <= est;
            STEP_FIX:  rem_ff  <= fix[XW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign done      = done_ff;
   assign remainder = REM_W'(rem_ff);

endmodule
